@@ hw/rtl/bppc_pkg.sv @@
// ----------------------------------------------------------------------------
// bppc_pkg
// Shared types, codes and helpers for the bit-parallel pattern counter.
// ----------------------------------------------------------------------------
package bppc_pkg;

  // default sizes
  localparam int MAX_PATTERN_DEF = 64;
  localparam int ALPHABET_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  // fixed field widths
  localparam int CFG_W  = 7;
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 2;
  localparam int OUT_W  = 32;
  localparam int TPOS_W = 32;

  // command codes of an input word
  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PAT_WR,
    S_TXT_EVAL,
    S_CHK_WIN,
    S_CHK_MSK,
    S_CHK_AND,
    S_COUNT,
    S_FINISH,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic pat_wr;
    logic txt_eval;
    logic chk_win;
    logic chk_msk;
    logic chk_and;
    logic count;
    logic finish;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eval_chk;
    logic eval_cnt;
    logic chk_done;
    logic pc_zero;
    logic last;
    logic active;
    logic out_busy;
  } dp_stat_t;

  // ones in one byte
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/bppc_ram.sv @@
// ----------------------------------------------------------------------------
// bppc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bppc_dp.sv @@
// ----------------------------------------------------------------------------
// bppc_dp
// Datapath: mask table, text window, candidate vector, count and output.
// ----------------------------------------------------------------------------
module bppc_dp
  import bppc_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int ALPHABET    = ALPHABET_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [CFG_W-1:0]  cfg_pattern_length,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic              in_last_byte,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_match_count,
  input  ctrl_cmd_t         ctl,
  output dp_stat_t          st
);

  localparam int MW  = $clog2(MAX_PATTERN + 1);
  localparam int AW  = $clog2(ALPHABET);
  localparam int WD  = 2 * MAX_PATTERN - 1;
  localparam int WW  = $clog2(WD);
  localparam int NCH = (MAX_PATTERN + 7) / 8;
  localparam int PCW = NCH * 8;
  localparam logic [MAX_PATTERN-1:0] ONES = {MAX_PATTERN{1'b1}};

  logic [CFG_W-1:0]       cfg_r;
  logic [MW-1:0]          m_r;
  logic                   last_r;
  logic [AW-1:0]          mrd_addr_r;
  logic                   mrd_ok_r;
  logic [ALPHABET-1:0]    valid_r;
  logic [MW-1:0]          pat_pos_r;
  logic [WW-1:0]          wp_r;
  logic [WW-1:0]          cur_r;
  logic [TPOS_W-1:0]      tpos_r;
  logic [MW-1:0]          phase_r;
  logic [MAX_PATTERN-1:0] cand_r;
  logic                   active_r;
  logic [MW-1:0]          t_r;
  logic [PCW-1:0]         pc_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_cnt_r;

  logic [MW-1:0]          m_eff;
  logic [MAX_PATTERN-1:0] full;
  logic [MAX_PATTERN-1:0] mword;
  logic [MAX_PATTERN-1:0] mask_rdata;
  logic [MAX_PATTERN-1:0] mask_wdata;
  logic                   mask_we;
  logic [AW-1:0]          mask_raddr;
  logic [BYTE_W-1:0]      win_rdata;
  logic [WW-1:0]          win_raddr;
  logic                   win_we;
  logic [MW:0]            ph_inc;
  logic [MW-1:0]          phase_nxt;
  logic [MW-1:0]          m_dec;
  logic [MAX_PATTERN-1:0] right_d;
  logic [MAX_PATTERN-1:0] left_d;
  logic [MAX_PATTERN-1:0] tail_d;
  logic [WW:0]            idx_w;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] count_add;
  logic [63:0]            count_ext;
  logic                   take_ok;
  logic                   rd_ok;
  cmd_t                   cmd;

  assign cmd = cmd_t'(in_cmd);

  // effective pattern length, clamped
  always_comb begin
    if (cfg_r < CFG_W'(2)) begin
      m_eff = MW'(2);
    end else if (32'(cfg_r) > MAX_PATTERN) begin
      m_eff = MW'(MAX_PATTERN);
    end else begin
      m_eff = MW'(cfg_r);
    end
  end

  // mask word of the byte just read, zero for unwritten entries
  assign full  = ~(ONES << m_r);
  assign mword = (mrd_ok_r && valid_r[mrd_addr_r]) ? mask_rdata : '0;
  assign m_dec = m_r - MW'(1);

  // phase advance with the new length
  assign ph_inc    = {1'b0, phase_r} + (MW+1)'(1);
  assign phase_nxt = (ph_inc >= {1'b0, m_eff}) ? '0 : ph_inc[MW-1:0];

  // narrowing terms
  assign right_d = cand_r & full & ((mword >> phase_r) | (ONES << (m_r - phase_r)));
  assign left_d  = cand_r & ((mword << t_r) | ~(ONES << t_r));
  assign tail_d  = cand_r & full & (ONES << (m_dec - phase_r));

  // window index of the byte t places back
  always_comb begin
    if ({1'b0, cur_r} >= (WW+1)'(t_r)) begin
      idx_w = {1'b0, cur_r} - (WW+1)'(t_r);
    end else begin
      idx_w = {1'b0, cur_r} + (WW+1)'(WD) - (WW+1)'(t_r);
    end
  end
  assign win_raddr = idx_w[WW-1:0];

  // saturating count step
  assign sum       = {1'b0, count_r} + (COUNT_WIDTH+1)'(popcount8(pc_r[7:0]));
  assign count_add = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
  assign count_ext = 64'(count_r);

  // memory port control
  assign take_ok    = ({1'b0, in_byte_value} < 9'(ALPHABET));
  assign rd_ok      = ({1'b0, win_rdata} < 9'(ALPHABET));
  assign mask_raddr = ctl.chk_msk ? win_rdata[AW-1:0] : in_byte_value[AW-1:0];
  assign mask_we    = ctl.pat_wr && (pat_pos_r < m_r) && mrd_ok_r;
  assign mask_wdata = mword | (MAX_PATTERN'(1) << pat_pos_r);
  assign win_we     = ctl.take && (cmd == CMD_TEXT);

  bppc_ram #(.WIDTH(MAX_PATTERN), .DEPTH(ALPHABET)) u_mask (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mrd_addr_r),
    .wdata (mask_wdata),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

  bppc_ram #(.WIDTH(BYTE_W), .DEPTH(WD)) u_win (
    .clk   (clk),
    .we    (win_we),
    .waddr (wp_r),
    .wdata (in_byte_value),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      m_r        <= m_eff;
      mrd_addr_r <= in_byte_value[AW-1:0];
      mrd_ok_r   <= take_ok;
      if (cmd == CMD_TEXT) begin
        cur_r <= wp_r;
      end
    end
    if (ctl.chk_msk) begin
      mrd_addr_r <= win_rdata[AW-1:0];
      mrd_ok_r   <= rd_ok;
    end
    if (ctl.emit) begin
      out_cnt_r <= count_ext[OUT_W-1:0];
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_W'(2);
      last_r      <= 1'b0;
      valid_r     <= '0;
      pat_pos_r   <= '0;
      wp_r        <= '0;
      tpos_r      <= '0;
      phase_r     <= '0;
      cand_r      <= '0;
      active_r    <= 1'b0;
      t_r         <= '0;
      pc_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_pattern_length;
      end

      // accept of a word
      if (ctl.take) begin
        last_r <= in_last_byte && (cmd == CMD_TEXT);
        case (cmd)
          CMD_START: begin
            valid_r   <= '0;
            pat_pos_r <= '0;
            tpos_r    <= '0;
            phase_r   <= '0;
            cand_r    <= '0;
            active_r  <= 1'b0;
            count_r   <= '0;
          end
          CMD_TEXT: begin
            wp_r    <= (wp_r == WW'(WD - 1)) ? '0 : wp_r + WW'(1);
            phase_r <= phase_nxt;
            if (tpos_r != '1) begin
              tpos_r <= tpos_r + TPOS_W'(1);
            end
          end
          default: ;
        endcase
      end

      // pattern byte into the table
      if (ctl.pat_wr && (pat_pos_r < m_r)) begin
        pat_pos_r <= pat_pos_r + MW'(1);
        if (mrd_ok_r) begin
          valid_r[mrd_addr_r] <= 1'b1;
        end
      end

      // text byte: open a checkpoint or narrow from the right
      if (ctl.txt_eval) begin
        if (phase_r == '0) begin
          if (tpos_r >= TPOS_W'(m_r)) begin
            cand_r <= mword & full;
            t_r    <= MW'(1);
          end else begin
            cand_r   <= '0;
            active_r <= 1'b0;
          end
        end else if (active_r) begin
          if (phase_r == m_dec) begin
            pc_r     <= PCW'(right_d);
            cand_r   <= '0;
            active_r <= 1'b0;
          end else begin
            cand_r <= right_d;
          end
        end
      end

      // narrow from the left, one byte per pass
      if (ctl.chk_and) begin
        cand_r <= left_d;
        t_r    <= t_r + MW'(1);
        if (t_r == m_dec) begin
          active_r <= 1'b1;
        end
      end

      // popcount, one byte per cycle
      if (ctl.count) begin
        count_r <= count_add;
        pc_r    <= pc_r >> 8;
      end

      // end of text: alignments already complete
      if (ctl.finish && last_r && active_r) begin
        pc_r     <= PCW'(tail_d);
        cand_r   <= '0;
        active_r <= 1'b0;
      end

      // result word
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
        tpos_r      <= '0;
        phase_r     <= '0;
        cand_r      <= '0;
        active_r    <= 1'b0;
        count_r     <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // status to the controller
  always_comb begin
    st          = '0;
    st.eval_chk = (phase_r == '0) && (tpos_r >= TPOS_W'(m_r));
    st.eval_cnt = (phase_r != '0) && active_r && (phase_r == m_dec);
    st.chk_done = (t_r == m_dec);
    st.pc_zero  = (pc_r == '0);
    st.last     = last_r;
    st.active   = active_r;
    st.out_busy = out_valid_r;
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = out_cnt_r;

endmodule

@@ hw/rtl/bppc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bppc_ctrl
// Controller: sequences table updates, checkpoint checks, counting and output.
// ----------------------------------------------------------------------------
module bppc_ctrl
  import bppc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  logic             out_ready,
  input  dp_stat_t         st,
  output ctrl_cmd_t        ctl
);

  state_t state_r;
  state_t state_nxt;
  logic   can_emit;

  assign can_emit = !st.out_busy || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(in_cmd))
            CMD_PATTERN: state_nxt = S_PAT_WR;
            CMD_TEXT:    state_nxt = S_TXT_EVAL;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_PAT_WR:   state_nxt = S_IDLE;
      S_TXT_EVAL: begin
        if (st.eval_chk) begin
          state_nxt = S_CHK_WIN;
        end else if (st.eval_cnt) begin
          state_nxt = S_COUNT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_CHK_WIN:  state_nxt = S_CHK_MSK;
      S_CHK_MSK:  state_nxt = S_CHK_AND;
      S_CHK_AND:  state_nxt = st.chk_done ? S_FINISH : S_CHK_WIN;
      S_COUNT:    state_nxt = st.pc_zero ? S_FINISH : S_COUNT;
      S_FINISH: begin
        if (!st.last) begin
          state_nxt = S_IDLE;
        end else if (st.active) begin
          state_nxt = S_COUNT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT:     state_nxt = can_emit ? S_IDLE : S_EMIT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.take = in_valid;
      end
      S_PAT_WR:   ctl.pat_wr   = 1'b1;
      S_TXT_EVAL: ctl.txt_eval = 1'b1;
      S_CHK_WIN:  ctl.chk_win  = 1'b1;
      S_CHK_MSK:  ctl.chk_msk  = 1'b1;
      S_CHK_AND:  ctl.chk_and  = 1'b1;
      S_COUNT:    ctl.count    = 1'b1;
      S_FINISH:   ctl.finish   = 1'b1;
      S_EMIT:     ctl.emit     = can_emit;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/bit_parallel_pattern_count.sv @@
// ----------------------------------------------------------------------------
// bit_parallel_pattern_count
// Counts exact occurrences of a loaded byte pattern in a streamed text.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel sets the pattern length m (2..MAX_PATTERN, clamped), while idle.
//   in channel takes one word at a time: cmd start clears the mask table and
//   the text state, cmd pattern loads the next pattern byte, cmd text streams
//   a text byte; last_byte on a text word closes the text.
//   out channel carries the match count, one word per closed text.
// Sequence:
//   start and unused cmd: taken alone; pattern byte: taken, then written.
//   text byte: taken, evaluated, then finished; at every m-th byte the checkpoint walks the
//   m-1 previous bytes through the window RAM and mask RAM; a popcount step
//   (one byte of the vector per cycle) follows when a candidate completes or
//   the text ends. A closing text byte adds an emit step.
// Reset: mask table empty, m = 2, count zero, no output pending.
// Stall: a count waiting on out does not block input; only the next count
//   waits until the previous one has been taken.
// ----------------------------------------------------------------------------
module bit_parallel_pattern_count
  import bppc_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int ALPHABET    = ALPHABET_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_pattern_length,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_match_count
);

  ctrl_cmd_t ctl;
  dp_stat_t  st;

  // config register always writable
  assign cfg_ready = 1'b1;

  bppc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  bppc_dp #(
    .MAX_PATTERN (MAX_PATTERN),
    .ALPHABET    (ALPHABET),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_pattern_length (cfg_pattern_length),
    .in_cmd             (in_cmd),
    .in_byte_value      (in_byte_value),
    .in_last_byte       (in_last_byte),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_match_count    (out_match_count),
    .ctl                (ctl),
    .st                 (st)
  );

endmodule
